// ===== rtl/bf3_pkg.sv =====
// Shared constants, types and the divisor table of the 3x3 box filter.
// Used by every module of the block; depends on nothing else.
package bf3_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 4096;

    localparam int PIX_W    = 8;
    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int ROW_W    = $clog2(MAX_HEIGHT);
    localparam int EFFW_W   = COL_W + 1;
    localparam int EFFH_W   = ROW_W + 1;
    localparam int DRN_W    = COL_W + 1;
    localparam int WIDTH_W  = 12;
    localparam int HEIGHT_W = 13;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = HEIGHT_W;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    localparam int LSUM_W = PIX_W + 1;
    localparam int CSUM_W = PIX_W + 2;
    localparam int SUM_W  = 12;
    localparam int CNT_W  = 4;

    // Quotients come from a multiply by a rounded-up reciprocal; a 16-bit
    // shift is exact for every sum below 4096 and every divisor used here.
    localparam int RECIP_SHIFT = 16;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam int RECIP_DIV1  = 2 ** RECIP_SHIFT;
    localparam int RECIP_DIV2  = (2 ** RECIP_SHIFT + 1) / 2;
    localparam int RECIP_DIV3  = (2 ** RECIP_SHIFT + 2) / 3;
    localparam int RECIP_DIV4  = (2 ** RECIP_SHIFT + 3) / 4;
    localparam int RECIP_DIV6  = (2 ** RECIP_SHIFT + 5) / 6;
    localparam int RECIP_DIV9  = (2 ** RECIP_SHIFT + 8) / 9;

    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

    typedef enum logic {
        OP_PIXEL,
        OP_DRAIN
    } op_t;

    // One word from the front to the back: a classified item with its
    // column sums already formed from the line buffers.
    typedef struct packed {
        op_t               op;
        logic [CSUM_W-1:0] colsum;
        logic [LSUM_W-1:0] low_sum;
        logic              rows_ge1;
        logic              rows_ge2;
        logic              col_ge1;
        logic              col_ge2;
        logic              row_done;
        logic              first;
        logic              has_next;
        logic              fin;
    } entry_t;

    function automatic logic [RECIP_W-1:0] bf3_recip(input logic [CNT_W-1:0] count);
        logic [RECIP_W-1:0] r;
        unique case (count)
            4'd1:    r = RECIP_W'(RECIP_DIV1);
            4'd2:    r = RECIP_W'(RECIP_DIV2);
            4'd3:    r = RECIP_W'(RECIP_DIV3);
            4'd4:    r = RECIP_W'(RECIP_DIV4);
            4'd6:    r = RECIP_W'(RECIP_DIV6);
            4'd9:    r = RECIP_W'(RECIP_DIV9);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/bf3_front.sv =====
// Front end of the box filter: configuration registers, row and column
// counters, the two line buffers and the classification of input words.
// Depends on bf3_pkg.
module bf3_front
    import bf3_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic                   kind,
    input  logic [PIX_W-1:0]       pixel_value,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output logic                   q_push,
    output entry_t                 q_entry,
    input  logic [CMDQ_CW-1:0]     q_level
);

    typedef struct packed {
        op_t              op;
        logic             sel;
        logic [PIX_W-1:0] px;
        logic             rows_ge1;
        logic             rows_ge2;
        logic             col_ge1;
        logic             col_ge2;
        logic             row_done;
        logic             first;
        logic             has_next;
        logic             fin;
    } cmd_t;

    logic [WIDTH_W-1:0]  width_reg, width_next;
    logic [HEIGHT_W-1:0] height_reg, height_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [DRN_W-1:0]    drain_reg, drain_next;
    logic                draining_reg, draining_next;
    logic                a_valid_reg;
    cmd_t                a_cmd_reg, a_cmd_next;
    logic [PIX_W-1:0]    rd0_reg, rd1_reg;

    logic [PIX_W-1:0] buf0_mem [MAX_WIDTH];
    logic [PIX_W-1:0] buf1_mem [MAX_WIDTH];

    logic [EFFW_W-1:0] eff_w;
    logic [EFFH_W-1:0] eff_h;
    logic              accept, pix_ok, drn_ok, mem_en, we0, we1;
    logic [EFFW_W-1:0] col_inc;
    logic [EFFH_W-1:0] row_inc;
    logic [DRN_W-1:0]  drain_inc;
    logic              row_done, frame_done, drain_end;
    logic [COL_W-1:0]  mem_addr;
    logic [PIX_W-1:0]  own, other, own_m, other_m, px_m;
    logic [LSUM_W-1:0] low;
    logic              is_drn, use_own, use_other;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:  width_next  = cfg_data[WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: height_next = cfg_data[HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // Zero acts as one, and the sizes saturate at the buffer limits.
    always_comb
    begin
        if (width_reg == '0)
            eff_w = EFFW_W'(1);
        else if (width_reg > WIDTH_W'(MAX_WIDTH))
            eff_w = EFFW_W'(MAX_WIDTH);
        else
            eff_w = EFFW_W'(width_reg);

        if (height_reg == '0)
            eff_h = EFFH_W'(1);
        else if (height_reg > HEIGHT_W'(MAX_HEIGHT))
            eff_h = EFFH_W'(MAX_HEIGHT);
        else
            eff_h = EFFH_W'(height_reg);
    end

    assign full   = ({1'b0, q_level} + (CMDQ_CW + 1)'(a_valid_reg)) >= (CMDQ_CW + 1)'(CMDQ_DEPTH);
    assign accept = push && !full;
    // A pixel during a pending drain and a drain tick outside one are dropped here.
    assign pix_ok = accept && (kind == KIND_PIXEL) && !draining_reg;
    assign drn_ok = accept && (kind == KIND_DRAIN) && draining_reg;
    assign mem_en = pix_ok || drn_ok;

    assign col_inc    = {1'b0, col_reg} + EFFW_W'(1);
    assign row_inc    = {1'b0, row_reg} + EFFH_W'(1);
    assign drain_inc  = drain_reg + DRN_W'(1);
    assign row_done   = col_inc >= eff_w;
    assign frame_done = row_inc >= eff_h;
    assign drain_end  = drain_inc >= DRN_W'(eff_w);

    assign mem_addr = draining_reg ? drain_inc[COL_W-1:0] : col_reg;
    assign we0      = pix_ok && !row_reg[0];
    assign we1      = pix_ok && row_reg[0];

    always_comb
    begin
        row_next      = row_reg;
        col_next      = col_reg;
        drain_next    = drain_reg;
        draining_next = draining_reg;
        if (pix_ok)
        begin
            if (row_done)
            begin
                col_next = '0;
                if (frame_done)
                begin
                    draining_next = 1'b1;
                    drain_next    = '0;
                end
                else
                begin
                    row_next = row_inc[ROW_W-1:0];
                end
            end
            else
            begin
                col_next = col_inc[COL_W-1:0];
            end
        end
        else if (drn_ok)
        begin
            if (drain_end)
            begin
                draining_next = 1'b0;
                row_next      = '0;
                col_next      = '0;
                drain_next    = '0;
            end
            else
            begin
                drain_next = drain_inc;
            end
        end
    end

    always_comb
    begin
        a_cmd_next.op       = draining_reg ? OP_DRAIN : OP_PIXEL;
        a_cmd_next.sel      = row_reg[0];
        a_cmd_next.px       = pixel_value;
        a_cmd_next.rows_ge1 = row_reg != '0;
        a_cmd_next.rows_ge2 = row_reg >= ROW_W'(2);
        a_cmd_next.col_ge1  = col_reg != '0;
        a_cmd_next.col_ge2  = col_reg >= COL_W'(2);
        a_cmd_next.row_done = row_done;
        a_cmd_next.first    = drain_reg == '0;
        a_cmd_next.has_next = !drain_end;
        a_cmd_next.fin      = drain_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= WIDTH_W'(WIDTH_RESET);
            height_reg   <= HEIGHT_W'(HEIGHT_RESET);
            row_reg      <= '0;
            col_reg      <= '0;
            drain_reg    <= '0;
            draining_reg <= 1'b0;
            a_valid_reg  <= 1'b0;
        end
        else
        begin
            width_reg    <= width_next;
            height_reg   <= height_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            drain_reg    <= drain_next;
            draining_reg <= draining_next;
            a_valid_reg  <= mem_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_en)
            a_cmd_reg <= a_cmd_next;
    end

    // Buffer r&1 holds row r-2 until pixel (r, c) overwrites it; the read
    // returns the old word, so one address serves both.
    always_ff @(posedge clk)
    begin
        if (mem_en)
        begin
            rd0_reg <= buf0_mem[mem_addr];
            rd1_reg <= buf1_mem[mem_addr];
        end
        if (we0)
            buf0_mem[mem_addr] <= pixel_value;
        if (we1)
            buf1_mem[mem_addr] <= pixel_value;
    end

    always_comb
    begin
        own       = a_cmd_reg.sel ? rd1_reg : rd0_reg;
        other     = a_cmd_reg.sel ? rd0_reg : rd1_reg;
        is_drn    = a_cmd_reg.op == OP_DRAIN;
        use_own   = is_drn ? a_cmd_reg.has_next : a_cmd_reg.rows_ge2;
        use_other = is_drn ? (a_cmd_reg.has_next && a_cmd_reg.rows_ge1) : a_cmd_reg.rows_ge1;
        own_m     = use_own ? own : '0;
        other_m   = use_other ? other : '0;
        px_m      = is_drn ? '0 : a_cmd_reg.px;
        low       = {1'b0, other_m} + {1'b0, px_m};

        q_entry.op       = a_cmd_reg.op;
        q_entry.colsum   = {1'b0, low} + {2'b00, own_m};
        q_entry.low_sum  = low;
        q_entry.rows_ge1 = a_cmd_reg.rows_ge1;
        q_entry.rows_ge2 = a_cmd_reg.rows_ge2;
        q_entry.col_ge1  = a_cmd_reg.col_ge1;
        q_entry.col_ge2  = a_cmd_reg.col_ge2;
        q_entry.row_done = a_cmd_reg.row_done;
        q_entry.first    = a_cmd_reg.first;
        q_entry.has_next = a_cmd_reg.has_next;
        q_entry.fin      = a_cmd_reg.fin;
    end

    assign q_push = a_valid_reg;

endmodule

// ===== rtl/bf3_cmd_queue.sv =====
// Short queue of classified words between the front and the back end.
// Depends on bf3_pkg.
module bf3_cmd_queue
    import bf3_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  entry_t             wdata,
    input  logic               pop,
    output entry_t             rdata,
    output logic               valid,
    output logic [CMDQ_CW-1:0] level
);

    entry_t               slot_reg [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0]   wp_reg, wp_next;
    logic [CMDQ_AW-1:0]   rp_reg, rp_next;
    logic [CMDQ_CW-1:0]   cnt_reg, cnt_next;
    logic                 do_pop;

    assign valid  = cnt_reg != '0;
    assign level  = cnt_reg;
    assign rdata  = slot_reg[rp_reg];
    assign do_pop = pop && valid;

    // The front reserves room before it accepts, so a push never overflows.
    always_comb
    begin
        wp_next  = push ? wp_reg + CMDQ_AW'(1) : wp_reg;
        rp_next  = do_pop ? rp_reg + CMDQ_AW'(1) : rp_reg;
        cnt_next = cnt_reg + CMDQ_CW'(push) - CMDQ_CW'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wp_reg] <= wdata;
    end

endmodule

// ===== rtl/bf3_back.sv =====
// Back end of the box filter: column window, neighbourhood sums, the
// reciprocal divide and the result queue. Depends on bf3_pkg.
module bf3_back
    import bf3_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  entry_t           q_entry,
    output logic             q_take,
    output logic             empty,
    input  logic             pop,
    output logic [PIX_W-1:0] smoothed_value,
    output logic             last_in_run,
    output logic             row_end,
    output logic             frame_end
);

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] count;
        logic             last;
        logic             rend;
        logic             fend;
    } res_t;

    typedef struct packed {
        logic [PIX_W-1:0] value;
        logic             last;
        logic             rend;
        logic             fend;
    } out_t;

    function automatic logic [CNT_W-1:0] bf3_count(input logic [1:0] a, input logic [1:0] b);
        return {2'b00, a} * {2'b00, b};
    endfunction

    logic [CSUM_W-1:0]  win1_reg, win1_next;
    logic [CSUM_W-1:0]  win2_reg, win2_next;
    logic [LSUM_W-1:0]  col0_reg, col0_next;
    logic               s1_valid_reg, s1_valid_next;
    logic               s1_two_reg, s1_two_next;
    res_t               s1_res_reg [2];
    out_t               outq_reg [OUTQ_DEPTH];
    logic [OUTQ_AW-1:0] wp_reg, wp_next;
    logic [OUTQ_AW-1:0] rp_reg, rp_next;
    logic [OUTQ_CW-1:0] cnt_reg, cnt_next;

    entry_t             e;
    res_t               res_a, res_b, slot0, slot1;
    logic               any_new, two_new;
    logic [1:0]         nr, nc_a, nc_b;
    logic [CSUM_W-1:0]  cur_d, prev_d;
    logic [OUTQ_CW:0]   s1_n;
    logic               go, pop_ok;
    logic [PROD_W-1:0]  prod0, prod1;
    out_t               out0, out1;
    logic [OUTQ_AW-1:0] wp_plus1;

    assign e = q_entry;

    always_comb
    begin
        res_a     = '0;
        res_b     = '0;
        slot0     = '0;
        slot1     = '0;
        any_new   = 1'b0;
        two_new   = 1'b0;
        nr        = e.rows_ge2 ? 2'd3 : 2'd2;
        nc_a      = e.col_ge2 ? 2'd3 : 2'd2;
        nc_b      = e.col_ge1 ? 2'd2 : 2'd1;
        cur_d     = e.first ? {1'b0, col0_reg} : win1_reg;
        prev_d    = e.first ? '0 : win2_reg;
        win1_next = win1_reg;
        win2_next = win2_reg;
        col0_next = col0_reg;
        if (e.op == OP_PIXEL)
        begin
            // Result A centers on the previous column, result B on the
            // current one and appears only at the end of a row.
            res_a.sum   = SUM_W'(win1_reg) + SUM_W'(e.colsum)
                          + (e.col_ge2 ? SUM_W'(win2_reg) : '0);
            res_a.count = bf3_count(nc_a, nr);
            res_a.last  = !e.row_done;
            res_b.sum   = SUM_W'(e.colsum) + (e.col_ge1 ? SUM_W'(win1_reg) : '0);
            res_b.count = bf3_count(nc_b, nr);
            res_b.last  = 1'b1;
            res_b.rend  = 1'b1;
            slot0       = e.col_ge1 ? res_a : res_b;
            slot1       = res_b;
            any_new     = e.rows_ge1 && (e.col_ge1 || e.row_done);
            two_new     = e.rows_ge1 && e.col_ge1 && e.row_done;
            win1_next   = e.colsum;
            win2_next   = win1_reg;
            col0_next   = e.col_ge1 ? col0_reg : e.low_sum;
        end
        else
        begin
            // While draining, the window holds the last two rows only.
            slot0.sum   = SUM_W'(prev_d) + SUM_W'(cur_d) + SUM_W'(e.colsum);
            slot0.count = bf3_count((e.first ? 2'd1 : 2'd2) + {1'b0, e.has_next},
                                    e.rows_ge1 ? 2'd2 : 2'd1);
            slot0.last  = 1'b1;
            slot0.rend  = e.fin;
            slot0.fend  = e.fin;
            slot1       = slot0;
            any_new     = 1'b1;
            win1_next   = e.colsum;
            win2_next   = cur_d;
        end
    end

    assign s1_n   = s1_valid_reg ? (s1_two_reg ? (OUTQ_CW + 1)'(2) : (OUTQ_CW + 1)'(1)) : '0;
    assign go     = s1_valid_reg && (({1'b0, cnt_reg} + s1_n) <= (OUTQ_CW + 1)'(OUTQ_DEPTH));
    assign q_take = q_valid && (!s1_valid_reg || go);

    always_comb
    begin
        if (q_take)
        begin
            s1_valid_next = any_new;
            s1_two_next   = two_new;
        end
        else if (go)
        begin
            s1_valid_next = 1'b0;
            s1_two_next   = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
            s1_two_next   = s1_two_reg;
        end
    end

    always_comb
    begin
        prod0      = PROD_W'(s1_res_reg[0].sum) * PROD_W'(bf3_recip(s1_res_reg[0].count));
        prod1      = PROD_W'(s1_res_reg[1].sum) * PROD_W'(bf3_recip(s1_res_reg[1].count));
        out0.value = prod0[RECIP_SHIFT +: PIX_W];
        out0.last  = s1_res_reg[0].last;
        out0.rend  = s1_res_reg[0].rend;
        out0.fend  = s1_res_reg[0].fend;
        out1.value = prod1[RECIP_SHIFT +: PIX_W];
        out1.last  = s1_res_reg[1].last;
        out1.rend  = s1_res_reg[1].rend;
        out1.fend  = s1_res_reg[1].fend;
    end

    assign empty    = cnt_reg == '0;
    assign pop_ok   = pop && !empty;
    assign wp_plus1 = wp_reg + OUTQ_AW'(1);

    always_comb
    begin
        wp_next  = go ? wp_reg + OUTQ_AW'(s1_n) : wp_reg;
        rp_next  = pop_ok ? rp_reg + OUTQ_AW'(1) : rp_reg;
        cnt_next = OUTQ_CW'({1'b0, cnt_reg} + (go ? s1_n : '0) - (OUTQ_CW + 1)'(pop_ok));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_two_reg   <= 1'b0;
            wp_reg       <= '0;
            rp_reg       <= '0;
            cnt_reg      <= '0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s1_two_reg   <= s1_two_next;
            wp_reg       <= wp_next;
            rp_reg       <= rp_next;
            cnt_reg      <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_take)
        begin
            win1_reg      <= win1_next;
            win2_reg      <= win2_next;
            col0_reg      <= col0_next;
            s1_res_reg[0] <= slot0;
            s1_res_reg[1] <= slot1;
        end
        if (go)
        begin
            outq_reg[wp_reg] <= out0;
            if (s1_two_reg)
                outq_reg[wp_plus1] <= out1;
        end
    end

    assign smoothed_value = outq_reg[rp_reg].value;
    assign last_in_run    = outq_reg[rp_reg].last;
    assign row_end        = outq_reg[rp_reg].rend;
    assign frame_end      = outq_reg[rp_reg].fend;

endmodule

// ===== rtl/box_filter_3x3_clamped_border.sv =====
// Top level of the streaming 3x3 box filter with clamped borders.
// Instantiates bf3_front, bf3_cmd_queue and bf3_back; depends on bf3_pkg.
//
// Pixels enter in raster order, one word per clock while full is low, and each
// output is the truncated mean of the pixel's 3x3 neighbourhood restricted to
// the image, so border pixels divide by 6, 4, 3, 2 or 1 instead of 9. Outputs
// trail the input by one row and one column; once the last pixel of a frame is
// in, each drain word releases one pixel of the last row, and pixels sent during
// a drain are dropped. Two line buffers of 2048 bytes, each read and written at
// one address per cycle, set that rate. A result passes the input registers, the
// command queue, the result register and the output queue; the two results of a
// row-end pixel enter that queue together. The line buffers have no clearing
// pass and are usable right after reset. Image size is to be written through the
// configuration port only while the block is idle; the block does not enforce it.
module box_filter_3x3_clamped_border
    import bf3_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic                   kind,
    input  logic [PIX_W-1:0]       pixel_value,
    output logic                   empty,
    input  logic                   pop,
    output logic [PIX_W-1:0]       smoothed_value,
    output logic                   last_in_run,
    output logic                   row_end,
    output logic                   frame_end,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic               fq_push;
    entry_t             fq_entry;
    logic [CMDQ_CW-1:0] fq_level;
    entry_t             bq_entry;
    logic               bq_valid;
    logic               bq_take;

    bf3_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .kind        (kind),
        .pixel_value (pixel_value),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .q_push      (fq_push),
        .q_entry     (fq_entry),
        .q_level     (fq_level)
    );

    bf3_cmd_queue u_cmd_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fq_push),
        .wdata (fq_entry),
        .pop   (bq_take),
        .rdata (bq_entry),
        .valid (bq_valid),
        .level (fq_level)
    );

    bf3_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (bq_valid),
        .q_entry        (bq_entry),
        .q_take         (bq_take),
        .empty          (empty),
        .pop            (pop),
        .smoothed_value (smoothed_value),
        .last_in_run    (last_in_run),
        .row_end        (row_end),
        .frame_end      (frame_end)
    );

endmodule

// ===== rtl/bf3_checker.sv =====
// Port-level checks for the 3x3 box filter, attached to the top level by bind.
// Depends on bf3_pkg and box_filter_3x3_clamped_border.
module bf3_checker
    import bf3_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   push,
    input logic                   full,
    input logic                   empty,
    input logic                   pop,
    input logic [PIX_W-1:0]       smoothed_value,
    input logic                   last_in_run,
    input logic                   row_end,
    input logic                   frame_end
);

    // The end of a row or frame always closes the run of its input word.
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && (row_end || frame_end) |-> last_in_run && (row_end || !frame_end))
        else $error("row or frame end on a word that does not close its run");

    // Both results of a row-end pixel are queued together, so the second
    // one is waiting as soon as the first is taken.
    a_pair_together: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && pop && !last_in_run |=> !empty && row_end && last_in_run)
        else $error("second result of a pair is missing or malformed");

    // Without new input the front only drains, so it cannot fill up.
    a_full_needs_push: assert property (@(posedge clk) disable iff (!rst_n)
        !full && !push |=> !full)
        else $error("full rose with no input offered");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(smoothed_value) && $stable(last_in_run)
                           && $stable(row_end) && $stable(frame_end))
        else $error("waiting result changed before it was taken");

endmodule

bind box_filter_3x3_clamped_border bf3_checker u_bf3_checker (.*);
